// ===== hw/rtl/c3x3_pkg.sv =====
// ----------------------------------------------------------------------------
// c3x3_pkg
// Shared types and constants of the 3x3 interior convolution stream core.
// ----------------------------------------------------------------------------
package c3x3_pkg;

	// sizes and limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int MIN_SIZE       = 3;
	localparam int CFG_SIZE_W     = 11;
	localparam int KUP_W          = 48;
	localparam int KLO_W          = 24;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_ADDR_W     = 5;

	// datapath widths
	localparam int PIX_W          = 8;
	localparam int WT_W           = 8;
	localparam int WIN_ROWS       = 3;
	localparam int WIN_COLS       = 3;
	localparam int PROD_W         = PIX_W + 1 + WT_W;
	localparam int COLSUM_W       = PROD_W + 2;
	localparam int ACC_W          = COLSUM_W + 2;
	localparam int RES_SHIFT      = 4;
	localparam int VAL_W          = 16;
	localparam int COORD_W        = 10;
	localparam int TDATA_OUT_W    = 40;

	// output queue depth
	localparam int OQ_DEPTH       = 8;

	// reset values of the registers
	localparam logic [CFG_SIZE_W-1:0] RST_WIDTH  = CFG_SIZE_W'(4);
	localparam logic [CFG_SIZE_W-1:0] RST_HEIGHT = CFG_SIZE_W'(4);
	localparam logic [KUP_W-1:0]      RST_KUP    = 48'h0204_0201_0201;
	localparam logic [KLO_W-1:0]      RST_KLO    = 24'h01_0201;

	// register map, index = paddr[4:3]
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KUP    = 2'd2,
		REG_KLO    = 2'd3
	} reg_idx_t;

	// one column of the window, index 0 is the top row
	typedef logic [WIN_ROWS-1:0][PIX_W-1:0] pix_col_t;
	// weights of one window column, index 0 is the top row
	typedef logic [WIN_ROWS-1:0][WT_W-1:0]  wt_col_t;

	// position info that travels with an item
	typedef struct packed {
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} meta_t;

	// one finished result
	typedef struct packed {
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [VAL_W-1:0]   value;
	} res_t;

endpackage

// ===== hw/rtl/c3x3_cell.sv =====
// ----------------------------------------------------------------------------
// c3x3_cell
// One window column: holds three pixels, hands them on to its left neighbor
// and forms the weighted column sum over two pipeline stages.
// ----------------------------------------------------------------------------
module c3x3_cell
	import c3x3_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  pix_col_t                   col_in,
	input  wt_col_t                    wt,
	output pix_col_t                   col_out,
	output logic signed [COLSUM_W-1:0] col_sum_s4
);

	pix_col_t                  col_q;
	logic signed [PROD_W-1:0]  prod_s3 [WIN_ROWS];

	// column register, shifts once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// unsigned pixel times signed weight, one multiplier per row
	always_ff @(posedge clk) begin
		for (int k = 0; k < WIN_ROWS; k++) begin
			prod_s3[k] <= $signed({1'b0, col_q[k]}) * $signed(wt[k]);
		end
	end

	// column sum
	always_ff @(posedge clk) begin
		col_sum_s4 <= COLSUM_W'(prod_s3[0]) + COLSUM_W'(prod_s3[1])
			+ COLSUM_W'(prod_s3[2]);
	end

endmodule

// ===== hw/rtl/c3x3_linebuf.sv =====
// ----------------------------------------------------------------------------
// c3x3_linebuf
// Two line stores holding the two rows above the current one; one
// registered read and one write per cycle at separate addresses.
// ----------------------------------------------------------------------------
module c3x3_linebuf
	import c3x3_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PIX_W-1:0] rd_older_s1,
	output logic [PIX_W-1:0] rd_newer_s1,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_older,
	input  logic [PIX_W-1:0] wr_newer
);

	logic [PIX_W-1:0] older_mem [DEPTH];
	logic [PIX_W-1:0] newer_mem [DEPTH];

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_older_s1 <= older_mem[rd_addr];
			rd_newer_s1 <= newer_mem[rd_addr];
		end
	end

	// write back: newer row moves to older, pixel goes to newer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
	end

endmodule

// ===== hw/rtl/c3x3_ofifo.sv =====
// ----------------------------------------------------------------------------
// c3x3_ofifo
// Small output queue that decouples the result pipeline from the
// downstream handshake.
// ----------------------------------------------------------------------------
module c3x3_ofifo
	import c3x3_pkg::*;
#(
	parameter int DEPTH = OQ_DEPTH,
	localparam int PW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  res_t          push_data,
	output logic          out_valid,
	input  logic          out_ready,
	output res_t          out_data,
	output logic [CW-1:0] count
);

	res_t          buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign count     = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/conv3x3_interior_stream_core.sv =====
// ----------------------------------------------------------------------------
// conv3x3_interior_stream_core
// Streaming 3x3 convolution over the interior of a raster-order frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle; the line stores take one read and one
// write a cycle and the column cell chain shifts once per item.
// s_tready drops only while queued and in-flight results fill the 8-entry queue.
// A result passes the pipeline registers s1 to s4 and then the output queue to m_tvalid.
// Reset clears counters, window cells, output queue and registers to their
// defaults; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_interior_stream_core
	import c3x3_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// pixel input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,  // [7:0] pixel
	// result output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,  // [15:0] filtered_value, [25:16] out_row,
	                                         // [35:26] out_col, [39:36] zero
	output logic                   m_tlast,  // frame_last
	// register port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WSW  = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ?
		$clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
	localparam int HSW  = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_W) ?
		$clog2(MAX_HEIGHT + 1) : CFG_SIZE_W;
	localparam int OQCW = $clog2(OQ_DEPTH + 1);

	// registers
	logic [CFG_SIZE_W-1:0] width_q;
	logic [CFG_SIZE_W-1:0] height_q;
	logic [KUP_W-1:0]      kup_q;
	logic [KLO_W-1:0]      klo_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	// counters and size decode
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [WSW-1:0]        width_raw;
	logic [WSW-1:0]        width_eff;
	logic [HSW-1:0]        height_raw;
	logic [HSW-1:0]        height_eff;
	logic                  col_last;
	logic                  row_last;
	logic                  produce;
	logic                  accept;
	meta_t                 meta_in;

	// pipeline
	logic                  valid_s1;
	logic                  pv_s1, pv_s2, pv_s3, pv_s4;
	meta_t                 meta_s1, meta_s2, meta_s3, meta_s4;
	logic [PIX_W-1:0]      px_s1;
	logic [CW-1:0]         addr_s1;
	logic [PIX_W-1:0]      rd_older_s1;
	logic [PIX_W-1:0]      rd_newer_s1;
	pix_col_t              cur_col;

	// cell chain
	logic [8:0][WT_W-1:0]        kern;
	pix_col_t                    col_link [WIN_COLS];
	logic signed [COLSUM_W-1:0]  col_sum_s4 [WIN_COLS];
	logic signed [ACC_W-1:0]     acc;
	logic signed [ACC_W-1:0]     acc_shr;
	res_t                        res_push;

	// output queue
	res_t                  oq_data;
	logic [OQCW-1:0]       oq_count;
	logic [2:0]            inflight;
	logic [OQCW:0]         occupancy;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			kup_q    <= RST_KUP;
			klo_q    <= RST_KLO;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_SIZE_W-1:0];
				REG_KUP:    kup_q    <= pwdata[KUP_W-1:0];
				REG_KLO:    klo_q    <= pwdata[KLO_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
			REG_KUP:    prdata = CFG_DATA_W'(kup_q);
			REG_KLO:    prdata = CFG_DATA_W'(klo_q);
			default:    prdata = '0;
		endcase
	end

	// clamp sizes to the supported range
	assign width_raw  = WSW'(width_q);
	assign height_raw = HSW'(height_q);

	always_comb begin
		if (width_raw < WSW'(MIN_SIZE)) begin
			width_eff = WSW'(MIN_SIZE);
		end else if (width_raw > WSW'(MAX_WIDTH)) begin
			width_eff = WSW'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end
		if (height_raw < HSW'(MIN_SIZE)) begin
			height_eff = HSW'(MIN_SIZE);
		end else if (height_raw > HSW'(MAX_HEIGHT)) begin
			height_eff = HSW'(MAX_HEIGHT);
		end else begin
			height_eff = height_raw;
		end
	end

	// position decode for the incoming item
	assign col_last = (WSW'(col_q) + WSW'(1)) >= width_eff;
	assign row_last = (HSW'(row_q) + HSW'(1)) >= height_eff;
	assign produce  = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign accept   = s_tvalid && s_tready;

	assign meta_in.last = row_last && col_last;
	assign meta_in.col  = COORD_W'(col_q - 1'b1);
	assign meta_in.row  = COORD_W'(row_q - 1'b1);

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pv_s1    <= 1'b0;
			pv_s2    <= 1'b0;
			pv_s3    <= 1'b0;
			pv_s4    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			pv_s1    <= accept && produce;
			pv_s2    <= pv_s1;
			pv_s3    <= pv_s2;
			pv_s4    <= pv_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			addr_s1 <= col_q;
			meta_s1 <= meta_in;
		end
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
	end

	// line stores
	c3x3_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_linebuf (
		.clk         (clk),
		.rd_en       (accept),
		.rd_addr     (col_q),
		.rd_older_s1 (rd_older_s1),
		.rd_newer_s1 (rd_newer_s1),
		.wr_en       (valid_s1),
		.wr_addr     (addr_s1),
		.wr_older    (rd_newer_s1),
		.wr_newer    (px_s1)
	);

	// newest column of the window
	assign cur_col[0] = rd_older_s1;
	assign cur_col[1] = rd_newer_s1;
	assign cur_col[2] = px_s1;

	// weight n sits at byte n of the packed kernel
	assign kern = {klo_q, kup_q};

	// chain of column cells, newest column enters at the right end
	for (genvar j = 0; j < WIN_COLS; j++) begin : g_cell
		wt_col_t  wt;
		pix_col_t col_in;

		assign wt = {kern[6 + j], kern[3 + j], kern[j]};

		if (j == WIN_COLS - 1) begin : g_head
			assign col_in = cur_col;
		end else begin : g_body
			assign col_in = col_link[j + 1];
		end

		c3x3_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (valid_s1),
			.col_in     (col_in),
			.wt         (wt),
			.col_out    (col_link[j]),
			.col_sum_s4 (col_sum_s4[j])
		);
	end

	// final sum and floor shift
	assign acc     = ACC_W'(col_sum_s4[0]) + ACC_W'(col_sum_s4[1])
		+ ACC_W'(col_sum_s4[2]);
	assign acc_shr = acc >>> RES_SHIFT;

	assign res_push.value = acc_shr[VAL_W-1:0];
	assign res_push.row   = meta_s4.row;
	assign res_push.col   = meta_s4.col;
	assign res_push.last  = meta_s4.last;

	// output queue, input held back while it could overfill
	c3x3_ofifo #(
		.DEPTH (OQ_DEPTH)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pv_s4),
		.push_data (res_push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (oq_data),
		.count     (oq_count)
	);

	assign inflight  = 3'(pv_s1) + 3'(pv_s2) + 3'(pv_s3) + 3'(pv_s4);
	assign occupancy = (OQCW + 1)'(oq_count) + (OQCW + 1)'(inflight);
	assign s_tready  = occupancy < (OQCW + 1)'(OQ_DEPTH);

	// result packing
	assign m_tdata = {4'b0000, oq_data.col, oq_data.row, oq_data.value};
	assign m_tlast = oq_data.last;

endmodule
